### src/fpa_pkg.sv
// ============================================================================
// fpa_pkg
// Shared types and command codes for the Q24.8 fixed-point ALU.
// ============================================================================
package fpa_pkg;

    localparam int DATA_W = 32;   // port width of operands and result
    localparam int CMD_W  = 4;

    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic signed [DATA_W-1:0] t_word;

    localparam t_cmd CMD_ADD = 4'd0;
    localparam t_cmd CMD_SUB = 4'd1;
    localparam t_cmd CMD_MUL = 4'd2;
    localparam t_cmd CMD_DIV = 4'd3;
    localparam t_cmd CMD_GT  = 4'd4;
    localparam t_cmd CMD_LT  = 4'd5;
    localparam t_cmd CMD_GE  = 4'd6;
    localparam t_cmd CMD_LE  = 4'd7;
    localparam t_cmd CMD_NE  = 4'd8;
    localparam t_cmd CMD_EQ  = 4'd9;
    localparam t_cmd CMD_MIN = 4'd10;
    localparam t_cmd CMD_MAX = 4'd11;
    localparam t_cmd CMD_INC = 4'd12;
    localparam t_cmd CMD_DEC = 4'd13;
    localparam t_cmd CMD_ITF = 4'd14;   // integer to fixed
    localparam t_cmd CMD_FTI = 4'd15;   // fixed to integer

    // status bits that ride along with each result
    typedef struct packed {
        logic cmp;
        logic ovf;
        logic dbz;
    } t_flags;

endpackage

### src/fpa_if.sv
// ============================================================================
// fpa_if
// Valid/ready channels of the fixed-point ALU: command beat in, result beat out.
// ============================================================================
interface fpa_in_if import fpa_pkg::*; ;
    logic  valid;
    logic  ready;
    t_cmd  command;
    t_word operand_a;
    t_word operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ;
    logic  valid;
    logic  ready;
    t_word result;
    logic  compare_true;
    logic  overflow;
    logic  divide_by_zero;

    modport source (output valid, output result, output compare_true, output overflow,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input result, input compare_true, input overflow,
                    input divide_by_zero, output ready);
endinterface

### src/fpa_simple.sv
// ============================================================================
// fpa_simple
// Combinational ops: add/sub/inc/dec with saturation, compares, min/max,
// int<->fixed conversion. Mul and div results are filled in downstream.
// ============================================================================
module fpa_simple import fpa_pkg::*; #(
    parameter int W = 32,
    parameter int F = 8
) (
    input  t_cmd                i_cmd,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_res,
    output t_flags              o_flg
);

    localparam logic signed [W-1:0] SAT_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_LO = {1'b1, {(W-1){1'b0}}};

    logic [W:0]     w_sum, w_dif, w_inc, w_dec, w_wide;
    logic [W+F-1:0] w_itf;
    logic           w_itf_fit, w_lt, w_gt, w_eq, w_arith;

    assign w_sum = {i_a[W-1], i_a} + {i_b[W-1], i_b};
    assign w_dif = {i_a[W-1], i_a} - {i_b[W-1], i_b};
    assign w_inc = {i_a[W-1], i_a} + (W+1)'(1);
    assign w_dec = {i_a[W-1], i_a} - (W+1)'(1);

    // shifted value fits when the bits above the new sign all match it
    assign w_itf     = {i_a, {F{1'b0}}};
    assign w_itf_fit = (&w_itf[W+F-1:W-1]) || !(|w_itf[W+F-1:W-1]);

    assign w_lt = i_a < i_b;
    assign w_gt = i_a > i_b;
    assign w_eq = i_a == i_b;

    always_comb begin
        o_res   = '0;
        o_flg   = '0;
        w_wide  = w_sum;
        w_arith = 1'b0;
        case (i_cmd)
            CMD_ADD: begin
                w_wide  = w_sum;
                w_arith = 1'b1;
            end
            CMD_SUB: begin
                w_wide  = w_dif;
                w_arith = 1'b1;
            end
            CMD_INC: begin
                w_wide  = w_inc;
                w_arith = 1'b1;
            end
            CMD_DEC: begin
                w_wide  = w_dec;
                w_arith = 1'b1;
            end
            CMD_MUL: o_res = '0;
            CMD_DIV: o_flg.dbz = (i_b == '0);
            CMD_GT:  o_flg.cmp = w_gt;
            CMD_LT:  o_flg.cmp = w_lt;
            CMD_GE:  o_flg.cmp = !w_lt;
            CMD_LE:  o_flg.cmp = !w_gt;
            CMD_NE:  o_flg.cmp = !w_eq;
            CMD_EQ:  o_flg.cmp = w_eq;
            CMD_MIN: o_res = w_lt ? i_a : i_b;
            CMD_MAX: o_res = w_gt ? i_a : i_b;
            CMD_ITF: begin
                o_res     = w_itf_fit ? w_itf[W-1:0] : (i_a[W-1] ? SAT_LO : SAT_HI);
                o_flg.ovf = !w_itf_fit;
            end
            CMD_FTI: o_res = i_a >>> F;   // floor division by the scale
            default: o_res = '0;
        endcase

        if (w_arith) begin
            if (w_wide[W] != w_wide[W-1]) begin
                o_res     = w_wide[W] ? SAT_LO : SAT_HI;
                o_flg.ovf = 1'b1;
            end else begin
                o_res = w_wide[W-1:0];
            end
        end
    end

endmodule

### src/fpa_div_step.sv
// ============================================================================
// fpa_div_step
// One restoring-division step: shift in a numerator bit, trial subtract.
// ============================================================================
module fpa_div_step #(
    parameter int W = 32
) (
    input  logic [W-1:0] i_rem,
    input  logic         i_bit,
    input  logic [W-1:0] i_div,
    output logic [W-1:0] o_rem,
    output logic         o_qbit
);

    logic [W:0]   w_trial;
    logic [W+1:0] w_diff;

    // remainder stays below the divisor, so the trial value fits W+1 bits
    assign w_trial = {i_rem, i_bit};
    assign w_diff  = {1'b0, w_trial} - {2'b00, i_div};
    assign o_qbit  = !w_diff[W+1];
    assign o_rem   = o_qbit ? w_diff[W-1:0] : w_trial[W-1:0];

endmodule

### src/fpa_sign_sat.sv
// ============================================================================
// fpa_sign_sat
// Applies sign to a magnitude and saturates to the signed W-bit range.
// ============================================================================
module fpa_sign_sat #(
    parameter int W = 32
) (
    input  logic [2*W-1:0]      i_mag,
    input  logic                i_neg,
    output logic signed [W-1:0] o_res,
    output logic                o_ovf
);

    localparam logic signed [W-1:0] SAT_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_LO = {1'b1, {(W-1){1'b0}}};

    logic [W:0] w_top;
    logic       w_ge_half, w_is_half;

    // magnitude of exactly 2^(W-1) is still legal when negative
    assign w_top     = i_mag[2*W-1:W-1];
    assign w_ge_half = |w_top;
    assign w_is_half = (w_top == (W+1)'(1)) && (i_mag[W-2:0] == '0);
    assign o_ovf     = w_ge_half && !(i_neg && w_is_half);

    always_comb begin
        if (o_ovf) begin
            o_res = i_neg ? SAT_LO : SAT_HI;
        end else if (i_neg) begin
            o_res = -i_mag[W-1:0];
        end else begin
            o_res = i_mag[W-1:0];
        end
    end

endmodule

### src/fixed_point_q24_8_alu.sv
// ============================================================================
// fixed_point_q24_8_alu
// Pipelined signed Q24.8 ALU: add/sub/mul/div, compares, min/max, inc/dec,
// int<->fixed conversion, with saturation and divide-by-zero flags.
// ============================================================================
// Usage: one command beat in, one result beat out, in order, no state kept
// between beats. The block takes a new beat every cycle while the skid
// register is empty, and every command passes through the same stages, from
// operand capture to the output register. That depth is set by the divider,
// which resolves one quotient bit per pipeline stage; the other commands ride
// along the same stages so results never reorder. Mul and div round half away
// from zero. Any result outside the signed WORD_WIDTH-bit range is clamped and
// flags overflow; division by zero returns 0 with divide_by_zero set. Only the
// low WORD_WIDTH bits of each operand are used, and the result is sign
// extended to 32 bits. A one-entry skid register holds a result the sink has
// not taken, so the pipe keeps accepting beats as a stall begins and halts only
// while the skid register is full; i_in.ready comes straight from a flop.
// ============================================================================
module fixed_point_q24_8_alu import fpa_pkg::*; #(
    parameter int FRACTION_BITS = 8,
    parameter int WORD_WIDTH    = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);

    localparam int W        = WORD_WIDTH;
    localparam int F        = FRACTION_BITS;
    localparam int N        = W + 4;   // last stage, output register
    localparam int DIV_LAST = W + 2;   // stage holding the full quotient

    // rounding constant for the product: half an LSB of the result
    localparam logic [2*W-1:0] MUL_HALF = (2*W)'(64'd1 << (F - 1));

    // ---------------------------------------------------------------
    // Pipeline control: one shared advance, stalled only while the skid
    // register is full.
    // ---------------------------------------------------------------
    logic [N:1] r_v;
    logic       r_sk_v;
    logic       w_en;

    assign w_en       = !r_sk_v;
    assign i_in.ready = w_en;

    // ---------------------------------------------------------------
    // Stage 1: operand capture, magnitudes and result sign
    // ---------------------------------------------------------------
    logic signed [W-1:0] w_a, w_b;
    logic [W-1:0]        w_mag_a, w_mag_b;

    t_cmd                r1_cmd;
    logic signed [W-1:0] r1_a, r1_b;
    logic [W-1:0]        r1_mag_a, r1_mag_b;
    logic                r1_neg;

    assign w_a     = i_in.operand_a[W-1:0];
    assign w_b     = i_in.operand_b[W-1:0];
    assign w_mag_a = w_a[W-1] ? -w_a : w_a;
    assign w_mag_b = w_b[W-1] ? -w_b : w_b;

    // ---------------------------------------------------------------
    // Stage 2: simple ops, product, divider setup
    // ---------------------------------------------------------------
    logic signed [W-1:0] w_s_res;
    t_flags              w_s_flg;
    logic [2*W-1:0]      w_prod;
    logic [W+F-1:0]      w_num;
    logic [W-1:0]        w_num_hi;
    logic                w_big;

    fpa_simple #(.W(W), .F(F)) u_simple (
        .i_cmd (r1_cmd),
        .i_a   (r1_a),
        .i_b   (r1_b),
        .o_res (w_s_res),
        .o_flg (w_s_flg)
    );

    assign w_prod   = r1_mag_a * r1_mag_b;
    assign w_num    = {r1_mag_a, {F{1'b0}}};
    assign w_num_hi = W'(w_num >> W);
    // quotient needs more than W bits: saturates whatever the sign
    assign w_big    = w_num_hi >= r1_mag_b;

    // common result path, carried to the output
    logic signed [W-1:0] r_res    [2:N];
    t_flags              r_flg    [2:N];
    logic                r_neg    [2:N-1];
    logic                r_is_div [2:N-1];
    logic                r_big    [2:N-1];
    logic                r_is_mul [2:3];

    // multiplier path
    logic [2*W-1:0]      r2_prod;
    logic [2*W-1:0]      r3_mr;
    logic signed [W-1:0] w_mul_res;
    logic                w_mul_ovf;

    fpa_sign_sat #(.W(W)) u_mul_sat (
        .i_mag (r3_mr),
        .i_neg (r_neg[3]),
        .o_res (w_mul_res),
        .o_ovf (w_mul_ovf)
    );

    // ---------------------------------------------------------------
    // Divider: one restoring step per stage, stages 3 .. W+2
    // ---------------------------------------------------------------
    logic [W-1:0] r_d   [2:DIV_LAST];
    logic [W-1:0] r_rem [2:DIV_LAST];
    logic [W-1:0] r_nlo [2:DIV_LAST];   // numerator bits still to shift in
    logic [W-1:0] r_q   [2:DIV_LAST];
    logic [W-1:0] w_rem_nx [3:DIV_LAST];
    logic         w_qbit   [3:DIV_LAST];

    for (genvar k = 3; k <= DIV_LAST; k++) begin : g_div
        fpa_div_step #(.W(W)) u_step (
            .i_rem  (r_rem[k-1]),
            .i_bit  (r_nlo[k-1][W-1]),
            .i_div  (r_d[k-1]),
            .o_rem  (w_rem_nx[k]),
            .o_qbit (w_qbit[k])
        );
    end

    // stage W+3: round half away from zero (2*rem >= divisor)
    logic         w_round;
    logic [W:0]   r_qr;
    assign w_round = {r_rem[DIV_LAST], 1'b0} >= {1'b0, r_d[DIV_LAST]};

    // stage W+4: sign and saturate the quotient
    logic [2*W-1:0]      w_div_mag;
    logic signed [W-1:0] w_div_res;
    logic                w_div_ovf;

    assign w_div_mag = {{(W-1){1'b0}}, r_qr[W] | r_big[N-1], r_qr[W-1:0]};

    fpa_sign_sat #(.W(W)) u_div_sat (
        .i_mag (w_div_mag),
        .i_neg (r_neg[N-1]),
        .o_res (w_div_res),
        .o_ovf (w_div_ovf)
    );

    // multiply lands in the result path at stage 4, divide at the last stage
    logic signed [W-1:0] n_res_mul, n_res_div;
    t_flags              n_flg_mul, n_flg_div;

    always_comb begin
        n_res_mul = r_res[3];
        n_flg_mul = r_flg[3];
        if (r_is_mul[3]) begin
            n_res_mul     = w_mul_res;
            n_flg_mul.ovf = w_mul_ovf;
        end
        // divide by zero keeps 0
        n_res_div = r_res[N-1];
        n_flg_div = r_flg[N-1];
        if (r_is_div[N-1] && !r_flg[N-1].dbz) begin
            n_res_div     = w_div_res;
            n_flg_div.ovf = w_div_ovf;
        end
    end

    // ---------------------------------------------------------------
    // Valid bits and skid control
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_sk_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_v <= {r_v[N-1:1], i_in.valid};
            end
            if (r_sk_v) begin
                if (o_out.ready) begin
                    r_sk_v <= 1'b0;
                end
            end else if (r_v[N] && !o_out.ready) begin
                r_sk_v <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload pipeline
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd   <= i_in.command;
            r1_a     <= w_a;
            r1_b     <= w_b;
            r1_mag_a <= w_mag_a;
            r1_mag_b <= w_mag_b;
            r1_neg   <= w_a[W-1] ^ w_b[W-1];

            r_res[2]    <= w_s_res;
            r_flg[2]    <= w_s_flg;
            r_neg[2]    <= r1_neg;
            r_is_div[2] <= (r1_cmd == CMD_DIV);
            r_is_mul[2] <= (r1_cmd == CMD_MUL);
            r_big[2]    <= w_big;
            r2_prod     <= w_prod;
            r_d[2]      <= r1_mag_b;
            r_rem[2]    <= w_num_hi;
            r_nlo[2]    <= w_num[W-1:0];
            r_q[2]      <= '0;

            for (int k = 3; k <= N; k++) begin
                if (k == 4) begin
                    r_res[k] <= n_res_mul;
                    r_flg[k] <= n_flg_mul;
                end else if (k == N) begin
                    r_res[k] <= n_res_div;
                    r_flg[k] <= n_flg_div;
                end else begin
                    r_res[k] <= r_res[k-1];
                    r_flg[k] <= r_flg[k-1];
                end
            end
            for (int k = 3; k <= N-1; k++) begin
                r_neg[k]    <= r_neg[k-1];
                r_is_div[k] <= r_is_div[k-1];
                r_big[k]    <= r_big[k-1];
            end
            r_is_mul[3] <= r_is_mul[2];

            r3_mr <= (r2_prod + MUL_HALF) >> F;

            for (int k = 3; k <= DIV_LAST; k++) begin
                r_d[k]   <= r_d[k-1];
                r_rem[k] <= w_rem_nx[k];
                r_q[k]   <= {r_q[k-1][W-2:0], w_qbit[k]};
                r_nlo[k] <= r_nlo[k-1] << 1;
            end

            r_qr <= {1'b0, r_q[DIV_LAST]} + (W+1)'(w_round);
        end
    end

    // skid register: catches the output beat the sink did not take
    logic signed [W-1:0] r_sk_res;
    t_flags              r_sk_flg;

    always_ff @(posedge i_clk) begin
        if (w_en && r_v[N] && !o_out.ready) begin
            r_sk_res <= r_res[N];
            r_sk_flg <= r_flg[N];
        end
    end

    // ---------------------------------------------------------------
    // Output beat
    // ---------------------------------------------------------------
    logic signed [W-1:0] w_out_res;
    t_flags              w_out_flg;

    assign w_out_res = r_sk_v ? r_sk_res : r_res[N];
    assign w_out_flg = r_sk_v ? r_sk_flg : r_flg[N];

    assign o_out.valid          = r_sk_v || r_v[N];
    assign o_out.result         = DATA_W'(w_out_res);
    assign o_out.compare_true   = w_out_flg.cmp;
    assign o_out.overflow       = w_out_flg.ovf;
    assign o_out.divide_by_zero = w_out_flg.dbz;

endmodule

### src/fpa_checker.sv
// ============================================================================
// fpa_checker
// Port-level checks on the fixed-point ALU, bound onto the top level.
// ============================================================================
module fpa_checker import fpa_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_word i_result,
    input logic  i_compare_true,
    input logic  i_overflow,
    input logic  i_divide_by_zero
);

    localparam int CNT_W = $clog2(WORD_WIDTH + 8) + 1;

    localparam logic signed [63:0]       HI64   = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0]       LO64   = -HI64 - 64'sd1;
    localparam logic signed [DATA_W-1:0] SAT_HI = HI64[DATA_W-1:0];
    localparam logic signed [DATA_W-1:0] SAT_LO = LO64[DATA_W-1:0];

    logic             w_in_fire, w_out_fire;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign w_in_fire  = i_in_valid && i_in_ready;
    assign w_out_fire = i_out_valid && i_out_ready;
    assign n_cnt      = r_cnt + CNT_W'(w_in_fire) - CNT_W'(w_out_fire);

    // beats in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // no result without an earlier command still in flight
    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire |-> r_cnt != '0)
        else $error("result beat with no command outstanding");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_compare_true |->
            i_result == '0 && !i_overflow && !i_divide_by_zero)
        else $error("compare result carries data or other flags");

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_divide_by_zero |-> i_result == '0 && !i_overflow)
        else $error("divide by zero result not cleared");

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> i_result == SAT_HI || i_result == SAT_LO)
        else $error("overflow flagged on an unclamped result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result))
        else $error("stalled result beat dropped or changed");

endmodule

bind fixed_point_q24_8_alu fpa_checker #(.WORD_WIDTH(WORD_WIDTH)) u_fpa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_result         (o_out.result),
    .i_compare_true   (o_out.compare_true),
    .i_overflow       (o_out.overflow),
    .i_divide_by_zero (o_out.divide_by_zero)
);
